// ----- src/cfs_pkg.sv -----
`timescale 1ns / 1ps
// Shared package of the CRC-checked frame synchroniser: controller states,
// command and status structures, CRC-16 constants and the byte-wise CRC step.
// Depends on nothing; cfs_ctrl, cfs_datapath, the top level and the testbench use it.
package cfs_pkg;

    localparam int PACKET_BYTES_DEF = 46;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'h1021;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CRC_RD,
        S_CRC_ACC,
        S_CHECK,
        S_EMIT_RD,
        S_EMIT_LOAD
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept_byte;
        logic flush;
        logic idx_clear;
        logic idx_inc;
        logic crc_init;
        logic crc_acc;
        logic check_pass;
        logic check_fail;
        logic out_load;
    } t_cmd;

    // Status from the datapath back to the controller.
    typedef struct packed {
        logic fill_last;
        logic idx_last;
        logic idx_pay_last;
        logic crc_match;
        logic out_free;
    } t_status;

    // One byte of CRC-16/CCITT-FALSE, MSB first.
    function automatic logic [15:0] crc_byte(input logic [15:0] crc_in,
                                             input logic [7:0]  data);
        logic [15:0] c;
        c = crc_in ^ {data, 8'h00};
        for (int b = 0; b < 8; b++) begin
            if (c[15]) begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

// ----- src/cfs_ram.sv -----
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
module cfs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 46
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

// ----- src/cfs_ctrl.sv -----
`timescale 1ns / 1ps
// Controller of the frame synchroniser: sequences byte intake, the CRC pass,
// the check and payload emission. Depends on cfs_pkg.
module cfs_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_in_mode,
    input  cfs_pkg::t_status  i_status,
    output logic              o_in_ready,
    output cfs_pkg::t_cmd     o_cmd
);
    import cfs_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid && !i_in_mode && i_status.fill_last) begin
                    n_state = S_CRC_RD;
                end
            end
            S_CRC_RD: begin
                n_state = S_CRC_ACC;
            end
            S_CRC_ACC: begin
                n_state = i_status.idx_last ? S_CHECK : S_CRC_RD;
            end
            S_CHECK: begin
                n_state = i_status.crc_match ? S_EMIT_RD : S_IDLE;
            end
            S_EMIT_RD: begin
                n_state = S_EMIT_LOAD;
            end
            S_EMIT_LOAD: begin
                if (i_status.out_free) begin
                    n_state = i_status.idx_pay_last ? S_IDLE : S_EMIT_RD;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    if (i_in_mode) begin
                        o_cmd.flush = 1'b1;
                    end else begin
                        o_cmd.accept_byte = 1'b1;
                        if (i_status.fill_last) begin
                            o_cmd.idx_clear = 1'b1;
                            o_cmd.crc_init  = 1'b1;
                        end
                    end
                end
            end
            S_CRC_RD: begin
            end
            S_CRC_ACC: begin
                o_cmd.crc_acc = 1'b1;
                o_cmd.idx_inc = !i_status.idx_last;
            end
            S_CHECK: begin
                if (i_status.crc_match) begin
                    o_cmd.check_pass = 1'b1;
                    o_cmd.idx_clear  = 1'b1;
                end else begin
                    o_cmd.check_fail = 1'b1;
                end
            end
            S_EMIT_RD: begin
            end
            S_EMIT_LOAD: begin
                if (i_status.out_free) begin
                    o_cmd.out_load = 1'b1;
                    o_cmd.idx_inc  = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

endmodule

// ----- src/cfs_datapath.sv -----
`timescale 1ns / 1ps
// Datapath of the frame synchroniser: circular byte window in RAM, CRC
// accumulator, failure counter and output register. Depends on cfs_pkg, cfs_ram.
module cfs_datapath #(
    parameter int PACKET_BYTES = cfs_pkg::PACKET_BYTES_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  cfs_pkg::t_cmd     i_cmd,
    input  logic [7:0]        i_rx_byte,
    input  logic              i_out_ready,
    output cfs_pkg::t_status  o_status,
    output logic              o_out_valid,
    output logic [7:0]        o_out_byte,
    output logic              o_out_last,
    output logic [31:0]       o_out_fail
);
    import cfs_pkg::*;

    localparam int AW = $clog2(PACKET_BYTES);
    localparam logic [AW:0]   DEPTH_W      = (AW+1)'(PACKET_BYTES);
    localparam logic [AW-1:0] IDX_LAST     = AW'(PACKET_BYTES - 1);
    localparam logic [AW-1:0] IDX_CRC_LO   = AW'(PACKET_BYTES - 2);
    localparam logic [AW-1:0] IDX_PAY_LAST = AW'(PACKET_BYTES - 3);
    localparam logic [AW-1:0] ONE          = AW'(1);

    // Addition modulo the window depth; both operands are below the depth.
    function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] a,
                                               input logic [AW-1:0] b);
        logic [AW:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= DEPTH_W) begin
            s = s - DEPTH_W;
        end
        return s[AW-1:0];
    endfunction

    logic [AW-1:0] r_head;
    logic [AW-1:0] r_fill;
    logic [AW-1:0] r_idx;
    logic [15:0]   r_crc;
    logic [7:0]    r_crc_lo;
    logic [7:0]    r_crc_hi;
    logic [31:0]   r_fail;
    logic          r_out_valid;
    logic [7:0]    r_out_byte;
    logic          r_out_last;
    logic [31:0]   r_out_fail;

    logic [AW-1:0] wr_addr;
    logic [AW-1:0] rd_addr;
    logic [7:0]    rd_data;
    logic          out_free;

    assign wr_addr  = wrap_add(r_head, r_fill);
    assign rd_addr  = wrap_add(r_head, r_idx);
    assign out_free = !r_out_valid || i_out_ready;

    cfs_ram #(
        .WIDTH (8),
        .DEPTH (PACKET_BYTES)
    ) u_window (
        .i_clk     (i_clk),
        .i_wr_en   (i_cmd.accept_byte),
        .i_wr_addr (wr_addr),
        .i_wr_data (i_rx_byte),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    // Window bookkeeping and failure count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head <= '0;
            r_fill <= '0;
            r_fail <= '0;
        end else begin
            if (i_cmd.flush || i_cmd.check_pass) begin
                r_fill <= '0;
            end else if (i_cmd.check_fail) begin
                r_head <= wrap_add(r_head, ONE);
                r_fill <= IDX_LAST;
                if (r_fail != '1) begin
                    r_fail <= r_fail + 32'd1;
                end
            end else if (i_cmd.accept_byte && (r_fill != IDX_LAST)) begin
                r_fill <= r_fill + ONE;
            end
        end
    end

    // Read index and CRC accumulation.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= '0;
        end else if (i_cmd.idx_clear) begin
            r_idx <= '0;
        end else if (i_cmd.idx_inc) begin
            r_idx <= r_idx + ONE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.crc_init) begin
            r_crc <= CRC_INIT;
        end else if (i_cmd.crc_acc) begin
            if (r_idx < IDX_CRC_LO) begin
                r_crc <= crc_byte(r_crc, rd_data);
            end else if (r_idx == IDX_CRC_LO) begin
                r_crc_lo <= rd_data;
            end else begin
                r_crc_hi <= rd_data;
            end
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_byte <= rd_data;
            r_out_last <= (r_idx == IDX_PAY_LAST);
            r_out_fail <= r_fail;
        end
    end

    assign o_status.fill_last    = (r_fill == IDX_LAST);
    assign o_status.idx_last     = (r_idx == IDX_LAST);
    assign o_status.idx_pay_last = (r_idx == IDX_PAY_LAST);
    assign o_status.crc_match    = (r_crc == {r_crc_hi, r_crc_lo});
    assign o_status.out_free     = out_free;

    assign o_out_valid = r_out_valid;
    assign o_out_byte  = r_out_byte;
    assign o_out_last  = r_out_last;
    assign o_out_fail  = r_out_fail;

endmodule

// ----- src/crc_checked_frame_sync.sv -----
`timescale 1ns / 1ps
// Top level of the CRC-checked frame synchroniser, built from cfs_ctrl and cfs_datapath.
// A request that fills the window is followed by a CRC pass (states CRC_RD and CRC_ACC
// for every window byte) and a check; a byte that does not fill the window is just stored.
// The input is held through the CRC pass, the check and emission; each payload byte takes
// an EMIT_RD and an EMIT_LOAD state, the load waiting on a busy sink (one RAM read port).
// Reset: synchronous, active low on i_rst_n; empties the window and zeroes the fail count.
module crc_checked_frame_sync #(
    parameter int PACKET_BYTES = cfs_pkg::PACKET_BYTES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Input request stream.
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
    input  logic        s_axis_tuser,   // [0] mode: 1 flushes the partial window
    // Result stream.
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // [7:0] payload_byte, [39:8] crc_fail_count
    output logic        m_axis_tlast    // last_byte
);
    import cfs_pkg::*;

    // The controller steps through intake, the CRC pass over the window, the
    // comparison with the two trailing CRC bytes and payload emission. The
    // window is a circular buffer, so dropping the oldest byte after a failed
    // check is just a move of the head pointer.
    t_cmd    cmd;
    t_status status;

    logic [7:0]  out_byte;
    logic [31:0] out_fail;

    cfs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_in_mode  (s_axis_tuser),
        .i_status   (status),
        .o_in_ready (s_axis_tready),
        .o_cmd      (cmd)
    );

    // The datapath holds the window, the CRC accumulator, the saturating
    // failure counter and the output register. A finished result can wait in
    // the output register while the next request is already being taken.
    cfs_datapath #(
        .PACKET_BYTES (PACKET_BYTES)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_rx_byte   (s_axis_tdata),
        .i_out_ready (m_axis_tready),
        .o_status    (status),
        .o_out_valid (m_axis_tvalid),
        .o_out_byte  (out_byte),
        .o_out_last  (m_axis_tlast),
        .o_out_fail  (out_fail)
    );

    // The failure count travels with each payload byte as it stood when the
    // packet passed its check.
    assign m_axis_tdata = {out_fail, out_byte};

endmodule

// ----- tb/tb_crc_checked_frame_sync.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for crc_checked_frame_sync: received bytes and flushes
// go in, and every payload byte that comes out is checked against a predictor.
// Depends on cfs_pkg and the crc_checked_frame_sync RTL only.
module tb_crc_checked_frame_sync;

    // The block is built with its default window size, and the predictor uses
    // the same figure.
    localparam int FRAME_LEN = cfs_pkg::PACKET_BYTES_DEF;
    localparam int PAYLOAD_LEN = FRAME_LEN - 2;

    // The values carried in tuser.
    localparam logic MODE_DATA = 1'b0;
    localparam logic MODE_FLUSH = 1'b1;

    // CRC-16/CCITT-FALSE, worked out bit by bit in the predictor.
    localparam logic [15:0] CCITT_SEED = 16'hFFFF;
    localparam logic [15:0] CCITT_POLY = 16'h1021;

    // Each side holds back in roughly this many cycles out of a hundred.
    localparam int IDLE_PERCENT = 28;
    localparam int RANDOM_REQUESTS = 30;
    // A gap of this length between handshakes, far beyond a full window check and
    // its payload emission, means a hang.
    localparam int STALL_LIMIT = 2000;
    localparam int SETTLE_CYCLES = 250;
    localparam int MAX_REPORTS = 10;

    typedef enum {
        FILL_RANDOM,
        FILL_ZEROS,
        FILL_ONES,
        FILL_EDGES
    } t_fill;

    // One payload byte as the block should deliver it.
    typedef struct packed {
        logic [7:0]  pay;
        logic        tail;
        logic [31:0] fails;
    } t_payload_exp;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;   // [7:0] rx_byte
    logic        s_axis_tuser;   // [0] mode: 1 flushes the partial window
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [39:0] m_axis_tdata;   // [7:0] payload_byte, [39:8] crc_fail_count
    logic        m_axis_tlast;   // last_byte

    // Predictor state: the window as the block should hold it, how much of it is
    // filled, and the failure tally.
    logic [7:0]   win_bytes [FRAME_LEN];
    int           win_fill = 0;
    logic [31:0]  fail_tally = '0;
    t_payload_exp payload_due [$];

    int  requests_sent = 0;
    int  results_seen = 0;
    int  mismatch_count = 0;
    int  stall_cycles = 0;
    // While this is set neither side inserts idle cycles.
    bit  steady_flow = 1'b0;

    crc_checked_frame_sync #(
        .PACKET_BYTES(FRAME_LEN)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    // CRC over the first len bytes, one bit at a time, MSB first: the bit that
    // leaves the top of the register, xored with the data bit, decides whether
    // the polynomial is folded back in.
    function automatic logic [15:0] ccitt_crc(input logic [7:0] octets [FRAME_LEN],
                                              input int len);
        logic [15:0] acc;
        logic        feedback;
        acc = CCITT_SEED;
        for (int i = 0; i < len; i++) begin
            for (int b = 7; b >= 0; b--) begin
                feedback = acc[15] ^ octets[i][b];
                acc = {acc[14:0], 1'b0} ^ (feedback ? CCITT_POLY : 16'h0000);
            end
        end
        return acc;
    endfunction

    // Updates the predicted window for one accepted request. A full window whose
    // trailing two bytes (low byte first) equal the CRC of the rest releases its
    // payload; otherwise the oldest byte is dropped and the failure tally grows,
    // stopping at its maximum.
    function automatic void track_request(input logic mode, input logic [7:0] rx);
        logic [15:0] sum;
        logic [15:0] carried;
        if (mode == MODE_FLUSH) begin
            win_fill = 0;
            return;
        end
        if (win_fill < FRAME_LEN) begin
            win_bytes[win_fill] = rx;
            win_fill++;
        end
        if (win_fill < FRAME_LEN) begin
            return;
        end
        sum = ccitt_crc(win_bytes, PAYLOAD_LEN);
        carried = {win_bytes[FRAME_LEN-1], win_bytes[FRAME_LEN-2]};
        if (sum == carried) begin
            for (int i = 0; i < PAYLOAD_LEN; i++) begin
                payload_due.push_back('{pay: win_bytes[i],
                                        tail: (i == PAYLOAD_LEN - 1),
                                        fails: fail_tally});
            end
            win_fill = 0;
        end else begin
            if (fail_tally != '1) begin
                fail_tally++;
            end
            for (int i = 0; i < FRAME_LEN - 1; i++) begin
                win_bytes[i] = win_bytes[i+1];
            end
            win_fill = FRAME_LEN - 1;
        end
    endfunction

    // Presents one request, starting and ending at a falling edge. Random idle
    // cycles come first, then the request is held until the block takes it.
    task automatic send_request(input logic mode, input logic [7:0] rx);
        while (!steady_flow && $urandom_range(0, 99) < IDLE_PERCENT) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= rx;
        s_axis_tuser <= mode;
        @(posedge i_clk);
        while (!s_axis_tready) begin
            @(posedge i_clk);
        end
        track_request(mode, rx);
        requests_sent++;
        @(negedge i_clk);
    endtask

    // Builds a frame with its CRC appended low byte first, optionally flips one
    // bit anywhere in it, and sends the first cut bytes of it.
    task automatic send_frame(input t_fill fill, input bit corrupt, input int cut);
        logic [7:0]  frame [FRAME_LEN];
        logic [15:0] sum;
        int          flip_at;
        int          bit_at;
        for (int i = 0; i < PAYLOAD_LEN; i++) begin
            case (fill)
                FILL_ZEROS: frame[i] = 8'h00;
                FILL_ONES:  frame[i] = 8'hFF;
                FILL_EDGES: frame[i] = i[0] ? 8'hFF : 8'h00;
                default:    frame[i] = 8'($urandom_range(0, 255));
            endcase
        end
        sum = ccitt_crc(frame, PAYLOAD_LEN);
        frame[FRAME_LEN-2] = sum[7:0];
        frame[FRAME_LEN-1] = sum[15:8];
        if (corrupt) begin
            flip_at = $urandom_range(0, FRAME_LEN - 1);
            bit_at = $urandom_range(0, 7);
            frame[flip_at][bit_at] = ~frame[flip_at][bit_at];
        end
        for (int i = 0; i < cut; i++) begin
            send_request(MODE_DATA, frame[i]);
        end
    endtask

    // Drops tvalid and holds off until every predicted payload byte has come out.
    // Its first wait is unconditional, so tvalid is never lowered and raised in one step.
    task automatic wait_for_results();
        s_axis_tvalid <= 1'b0;
        @(negedge i_clk);
        while (payload_due.size() != 0) begin
            @(negedge i_clk);
        end
    endtask

    task automatic send_noise(input int count);
        for (int i = 0; i < count; i++) begin
            send_request(MODE_DATA, 8'($urandom_range(0, 255)));
        end
    endtask

    // Flushes of an empty and of a partly filled window, with the byte lane set to
    // both extremes; the data on a flush request must be ignored.
    task automatic test_flush_cases();
        send_request(MODE_FLUSH, 8'hFF);
        send_request(MODE_DATA, 8'h00);
        send_request(MODE_DATA, 8'hFF);
        send_request(MODE_DATA, 8'h5A);
        send_request(MODE_FLUSH, 8'h00);
        send_request(MODE_FLUSH, 8'hA5);
    endtask

    // A clean frame of alternating all-zero and all-one bytes.
    task automatic test_valid_frame();
        send_frame(FILL_EDGES, 1'b0, FRAME_LEN);
    endtask

    // A frame with one flipped bit fails its check; the window then slides one
    // byte per request, failing each time, until a clean frame lines up again.
    task automatic test_crc_error();
        send_frame(FILL_RANDOM, 1'b1, FRAME_LEN);
        send_frame(FILL_ZEROS, 1'b0, FRAME_LEN);
    endtask

    // Stray bytes ahead of a frame must be shed by the sliding resync.
    task automatic test_resync_noise();
        send_request(MODE_FLUSH, 8'($urandom_range(0, 255)));
        send_noise(3);
        send_frame(FILL_ONES, 1'b0, FRAME_LEN);
    endtask

    // The sender stops until the block has drained all of the payload of the
    // frame just sent.
    task automatic test_drain_pause();
        wait_for_results();
    endtask

    // A whole frame with neither side idling.
    task automatic test_back_to_back();
        steady_flow = 1'b1;
        send_frame(FILL_RANDOM, 1'b0, FRAME_LEN);
        steady_flow = 1'b0;
    endtask

    // Mostly clean frames with random content; the rest are frames with a bit
    // error, frames cut short by a flush, stray bytes and lone flushes.
    task automatic test_random_traffic();
        int    first;
        int    pick;
        t_fill fill;
        first = requests_sent;
        while (requests_sent - first < RANDOM_REQUESTS) begin
            pick = $urandom_range(0, 99);
            case ($urandom_range(0, 9))
                0:       fill = FILL_ZEROS;
                1:       fill = FILL_ONES;
                default: fill = FILL_RANDOM;
            endcase
            if (pick < 55) begin
                send_frame(fill, 1'b0, FRAME_LEN);
            end else if (pick < 70) begin
                send_frame(fill, 1'b1, FRAME_LEN);
            end else if (pick < 80) begin
                send_frame(fill, 1'b0, $urandom_range(1, FRAME_LEN - 1));
                send_request(MODE_FLUSH, 8'($urandom_range(0, 255)));
            end else if (pick < 90) begin
                send_noise($urandom_range(1, 4));
            end else begin
                send_request(MODE_FLUSH, 8'($urandom_range(0, 255)));
            end
        end
    endtask

    // The result side changes tready at the falling edge only.
    always @(negedge i_clk) begin
        m_axis_tready <= steady_flow || ($urandom_range(0, 99) >= IDLE_PERCENT);
    end

    // Every payload byte taken is matched against the oldest prediction, field by
    // field. A byte with nothing predicted counts as a mismatch as well.
    always @(posedge i_clk) begin : result_check
        t_payload_exp want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (payload_due.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS) begin
                    $display("%0t: unexpected payload byte %02h last %0b fails %0d",
                             $realtime, m_axis_tdata[7:0], m_axis_tlast,
                             m_axis_tdata[39:8]);
                end
            end else begin
                want = payload_due.pop_front();
                if (m_axis_tdata[7:0] !== want.pay || m_axis_tlast !== want.tail ||
                    m_axis_tdata[39:8] !== want.fails) begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS) begin
                        $display({"%0t: result %0d expected byte %02h last %0b ",
                                  "fails %0d, got byte %02h last %0b fails %0d"},
                                 $realtime, results_seen, want.pay, want.tail,
                                 want.fails, m_axis_tdata[7:0], m_axis_tlast,
                                 m_axis_tdata[39:8]);
                    end
                end
            end
            results_seen++;
        end
    end

    // Ends the run if neither side completes a handshake for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) ||
            (m_axis_tvalid && m_axis_tready)) begin
            stall_cycles = 0;
        end else begin
            stall_cycles++;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("Mismatches found");
                $finish;
            end
        end
    end

    initial begin
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = 8'h00;
        s_axis_tuser = MODE_DATA;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_flush_cases();
        test_valid_frame();
        test_crc_error();
        test_resync_noise();
        test_drain_pause();
        test_back_to_back();
        test_random_traffic();

        // Let the last results out, then allow for a window check still running
        // on a request that produces nothing.
        wait_for_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0 && payload_due.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

// ----- files.f -----
src/cfs_pkg.sv
src/cfs_ram.sv
src/cfs_ctrl.sv
src/cfs_datapath.sv
src/crc_checked_frame_sync.sv
tb/tb_crc_checked_frame_sync.sv
